// File: hdl/kt4_pkg.sv
// ----------------------------------------------------------------------------
// kt4_pkg
// Shared types, codes and helper functions for the 4D Warnsdorff tour block.
// ----------------------------------------------------------------------------
package kt4_pkg;

  localparam int CoordW   = 3;
  localparam int CellW    = 4 * CoordW;
  localparam int Cells    = 1 << CellW;
  localparam int StepW    = 13;
  localparam int DegW     = 6;
  localparam int SideW    = 4;
  localparam int MoveW    = 6;
  localparam int NumMoves = 48;
  localparam logic [SideW-1:0] SideMax   = 4'd8;
  localparam logic [SideW-1:0] SideReset = 4'd8;

  typedef enum logic [1:0] {
    ST_PLACED   = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_STUCK    = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_CLEAR, S_PLACE, S_LOWER, S_SCAN,
    S_FIN_REJ, S_FIN_STUCK, S_FIN_MOVE
  } state_t;

  typedef logic [CoordW-1:0] coord_t;
  typedef coord_t [3:0] cell_t;
  typedef logic signed [2:0] delta_t;
  typedef delta_t [3:0] move_t;

  typedef struct packed {
    logic load_item;
    logic cnt_clr;
    logic best_clr;
    logic clear_en;
    logic place;
    logic move_en;
    logic proc_lower;
    logic proc_scan;
    logic fin_rej;
    logic fin_stuck;
    logic fin_move;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic start_ok;
    logic active;
    logic clear_done;
    logic moves_done;
    logic found;
    logic out_free;
  } stat_t;

  // Moves come in groups of eight per axis pair; within a group the low bit
  // swaps the magnitudes, the next bit signs the second axis, the top bit the first.
  function automatic move_t move_delta(input logic [MoveW-1:0] m);
    move_t  d;
    delta_t a;
    delta_t b;
    d = '0;
    a = m[0] ? 3'sd1 : 3'sd2;
    b = m[0] ? 3'sd2 : 3'sd1;
    if (!m[2]) a = -a;
    if (!m[1]) b = -b;
    case (m[5:3])
      3'd0: begin d[0] = a; d[1] = b; end
      3'd1: begin d[0] = a; d[2] = b; end
      3'd2: begin d[0] = a; d[3] = b; end
      3'd3: begin d[1] = a; d[2] = b; end
      3'd4: begin d[1] = a; d[3] = b; end
      3'd5: begin d[2] = a; d[3] = b; end
      default: d = '0;
    endcase
    return d;
  endfunction

  // Number of on-board knight neighbours of a cell.
  function automatic logic [DegW-1:0] cell_degree(input cell_t c,
                                                  input logic [SideW-1:0] bs);
    logic [3:0] sa;
    logic [3:0] sb;
    logic [6:0] diag;
    logic [6:0] prod;
    logic [1:0] ak;
    logic [1:0] bk;
    logic [SideW-1:0] cz;
    sa = '0;
    sb = '0;
    diag = '0;
    for (int k = 0; k < 4; k++) begin
      cz = {1'b0, c[k]};
      ak = 2'(cz >= 4'd1) + 2'(cz + 4'd1 < bs);
      bk = 2'(cz >= 4'd2) + 2'(cz + 4'd2 < bs);
      sa = sa + 4'(ak);
      sb = sb + 4'(bk);
      diag = diag + 7'(ak * bk);
    end
    prod = 7'(sa * sb);
    return DegW'(prod - diag);
  endfunction

  function automatic logic [StepW-1:0] side_pow4(input logic [SideW-1:0] bs);
    case (bs)
      4'd1: return 13'd1;
      4'd2: return 13'd16;
      4'd3: return 13'd81;
      4'd4: return 13'd256;
      4'd5: return 13'd625;
      4'd6: return 13'd1296;
      4'd7: return 13'd2401;
      4'd8: return 13'd4096;
      default: return 13'd0;
    endcase
  endfunction

endpackage

// File: hdl/kt4_ctrl.sv
// ----------------------------------------------------------------------------
// kt4_ctrl
// Sequencer for start, advance and result delivery of the tour walker.
// ----------------------------------------------------------------------------
module kt4_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  kt4_pkg::stat_t st,
  output kt4_pkg::cmd_t  cmd
);
  import kt4_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load_item = in_tvalid;
        if (in_tvalid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.cnt_clr = 1'b1;
        cmd.best_clr = 1'b1;
        if (st.is_start) begin
          state_nxt = st.start_ok ? S_CLEAR : S_FIN_REJ;
        end else begin
          state_nxt = st.active ? S_SCAN : S_FIN_REJ;
        end
      end
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (st.clear_done) state_nxt = S_PLACE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt = S_LOWER;
      end
      S_LOWER: begin
        cmd.move_en = 1'b1;
        cmd.proc_lower = 1'b1;
        if (st.moves_done) state_nxt = S_FIN_MOVE;
      end
      S_SCAN: begin
        cmd.move_en = 1'b1;
        cmd.proc_scan = 1'b1;
        if (st.moves_done) state_nxt = st.found ? S_PLACE : S_FIN_STUCK;
      end
      S_FIN_REJ: begin
        if (st.out_free) begin
          cmd.fin_rej = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FIN_STUCK: begin
        if (st.out_free) begin
          cmd.fin_stuck = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FIN_MOVE: begin
        if (st.out_free) begin
          cmd.fin_move = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: hdl/kt4_dp.sv
// ----------------------------------------------------------------------------
// kt4_dp
// Board memory, move scanner, walk state and result register.
// ----------------------------------------------------------------------------
module kt4_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [kt4_pkg::SideW-1:0]    cfg_wr_data,
  input  logic                         in_action,
  input  kt4_pkg::cell_t               in_start,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output kt4_pkg::cell_t               out_pos,
  output logic [kt4_pkg::StepW-1:0]    out_step,
  output logic [kt4_pkg::DegW-1:0]     out_deg,
  output kt4_pkg::status_t             out_status,
  input  kt4_pkg::cmd_t                cmd,
  output kt4_pkg::stat_t               st
);
  import kt4_pkg::*;

  logic [DegW:0] mem [Cells];
  logic [DegW:0] rdata_r;

  logic [SideW-1:0] bs_r;
  logic             action_r;
  cell_t            start_r;
  cell_t            cur_r;
  logic [StepW-1:0] step_r;
  logic             active_r;
  logic [CellW-1:0] cnt_r;
  logic             p_vld_r;
  logic [CellW-1:0] p_addr_r;
  logic             found_r;
  logic [DegW-1:0]  low_deg_r;
  cell_t            best_r;
  logic [DegW-1:0]  deg_r;
  logic             out_vld_r;

  move_t            mv;
  logic signed [4:0] nk [4];
  logic             on_board;
  cell_t            nb;
  logic             issue;
  logic             we;
  logic [CellW-1:0] waddr;
  logic [DegW:0]    wdata;
  cell_t            clr_cell;
  cell_t            tgt;
  logic             hit_lower;
  logic             hit_scan;
  logic [StepW-1:0] total;

  assign total = side_pow4(bs_r);
  assign mv = move_delta(cnt_r[MoveW-1:0]);
  assign issue = cmd.move_en && (cnt_r < CellW'(NumMoves));
  assign clr_cell = cnt_r;
  assign tgt = action_r ? best_r : start_r;

  always_comb begin
    on_board = 1'b1;
    for (int k = 0; k < 4; k++) begin
      nk[k] = $signed({2'b00, cur_r[k]}) + 5'(mv[k]);
      nb[k] = nk[k][CoordW-1:0];
      if (nk[k][4] || (nk[k][3:0] >= bs_r)) on_board = 1'b0;
    end
  end

  assign hit_lower = cmd.proc_lower && p_vld_r && !rdata_r[DegW] && (rdata_r[DegW-1:0] != '0);
  assign hit_scan  = cmd.proc_scan && p_vld_r && !rdata_r[DegW] &&
                     (!found_r || (rdata_r[DegW-1:0] < low_deg_r));

  always_comb begin
    we = 1'b0;
    waddr = p_addr_r;
    wdata = {1'b0, rdata_r[DegW-1:0] - DegW'(1)};
    if (cmd.clear_en) begin
      we = 1'b1;
      waddr = cnt_r;
      wdata = {1'b0, cell_degree(clr_cell, bs_r)};
    end else if (cmd.place) begin
      we = 1'b1;
      waddr = tgt;
      wdata = {1'b1, action_r ? low_deg_r : cell_degree(start_r, bs_r)};
    end else if (hit_lower) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[nb];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action_r <= in_action;
      start_r <= in_start;
    end
    p_addr_r <= nb;
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.clear_en || cmd.move_en) begin
      cnt_r <= cnt_r + CellW'(1);
    end
    if (cmd.best_clr) begin
      found_r <= 1'b0;
    end else if (hit_scan) begin
      found_r <= 1'b1;
      low_deg_r <= rdata_r[DegW-1:0];
      best_r <= p_addr_r;
    end
    if (cmd.place) begin
      deg_r <= action_r ? low_deg_r : cell_degree(start_r, bs_r);
    end
    if (cmd.fin_rej) begin
      out_pos <= '0;
      out_step <= '0;
      out_deg <= '0;
      out_status <= ST_REJECTED;
    end else if (cmd.fin_stuck) begin
      out_pos <= cur_r;
      out_step <= step_r;
      out_deg <= '0;
      out_status <= ST_STUCK;
    end else if (cmd.fin_move) begin
      out_pos <= cur_r;
      out_step <= step_r;
      out_deg <= deg_r;
      out_status <= (step_r == total) ? ST_COMPLETE : ST_PLACED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= SideReset;
      cur_r <= '0;
      step_r <= '0;
      active_r <= 1'b0;
      p_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      p_vld_r <= issue && on_board;
      if (cmd.place) begin
        cur_r <= tgt;
        step_r <= action_r ? step_r + StepW'(1) : StepW'(1);
      end
      if (cfg_wr_en) begin
        bs_r <= cfg_wr_data;
        active_r <= 1'b0;
      end else if (cmd.fin_stuck) begin
        active_r <= 1'b0;
      end else if (cmd.fin_move) begin
        active_r <= (step_r != total);
      end
      if (cmd.fin_rej || cmd.fin_stuck || cmd.fin_move) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;

  always_comb begin
    st.is_start = !action_r;
    st.start_ok = (bs_r != '0) && (bs_r <= SideMax) &&
                  ({1'b0, start_r[0]} < bs_r) && ({1'b0, start_r[1]} < bs_r) &&
                  ({1'b0, start_r[2]} < bs_r) && ({1'b0, start_r[3]} < bs_r);
    st.active = active_r;
    st.clear_done = (cnt_r == '1);
    st.moves_done = (cnt_r == CellW'(NumMoves + 1));
    st.found = found_r;
    st.out_free = !out_vld_r || out_tready;
  end

endmodule

// File: hdl/knight_tour_4d_warnsdorff.sv
// ----------------------------------------------------------------------------
// knight_tour_4d_warnsdorff
// Warnsdorff knight's tour walker on a four-dimensional board.
// ----------------------------------------------------------------------------
// Advance: two passes of 48 moves over the board memory port (scan for the
// lowest count, then lower the neighbours' counts).
// Start: a sweep rewrites all 4096 cells of the board memory.
// One beat is worked on at a time.
// Reset (rst_n low, synchronous): no walk active, side 8, output empty.
module knight_tour_4d_warnsdorff (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // start_x, start_y, start_z, start_w, zero pad
  input  logic        in_tuser,  // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // pos_x, pos_y, pos_z, pos_w, step_number,
                                 // chosen_degree, zero pad
  output logic [1:0]  out_tuser  // status
);
  import kt4_pkg::*;

  cmd_t             cmd;
  stat_t            st;
  cell_t            start_cell;
  cell_t            pos;
  logic [StepW-1:0] step;
  logic [DegW-1:0]  deg;
  status_t          status;

  assign start_cell[0] = in_tdata[2:0];
  assign start_cell[1] = in_tdata[5:3];
  assign start_cell[2] = in_tdata[8:6];
  assign start_cell[3] = in_tdata[11:9];

  kt4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  kt4_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_action   (in_tuser),
    .in_start    (start_cell),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_pos     (pos),
    .out_step    (step),
    .out_deg     (deg),
    .out_status  (status),
    .cmd         (cmd),
    .st          (st)
  );

  assign out_tdata = {1'b0, deg, step, pos[3], pos[2], pos[1], pos[0]};
  assign out_tuser = status;

  a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_REJECTED) |-> (out_tdata == '0))
    else $error("rejected beat carries data");

  a_cfg_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !st.active)
    else $error("walk still active after register write");

endmodule
